// ===== sv/vrs_pkg.sv =====
// Package for the vector register scoreboard: sizes, item kinds and field widths.
// No dependencies.
`timescale 1ns / 1ps

package vrs_pkg;

  localparam int QueueDepth = 8;
  localparam int VregCount  = 32;
  localparam int SlotW      = $clog2(QueueDepth);
  localparam int CntW       = $clog2(QueueDepth + 1);

  localparam int KindW      = 2;
  localparam int SlotIdW    = 3;
  localparam int MaskW      = 8;
  localparam int RegMaskW   = 32;
  localparam int PendW      = 4;

  localparam int InDataW    = 72;
  localparam int OutDataW   = 32;

  typedef enum logic [KindW-1:0] {
    KindIssue  = 2'd0,
    KindRetire = 2'd1,
    KindQuery  = 2'd2
  } kind_e;

  typedef logic [QueueDepth-1:0] slot_mask_t;

endpackage

// ===== sv/vector_register_scoreboard.sv =====
// Top level of the vector register scoreboard: input register, dependency logic
// and result register. Depends on vrs_pkg.
`timescale 1ns / 1ps

// Vector register scoreboard.
// Slave channel (s_axis_*) takes one command item per handshake: tuser holds the
// kind (issue, retire, query), tdata holds the register masks, the masked flag and
// the slot to retire or query. Master channel (m_axis_*) returns exactly one
// result item per command item, in order.
// Issue takes the lowest free slot and records RAW deps (writers of its sources,
// v0 included when masked) and WAR/WAW deps (writers and readers of its
// destinations). Retire drops the slot from every reader/writer set and dep set.
// Query reports the slot's dep sets and whether both are empty.
// Timing: a command item is captured in the input register on acceptance; once
// the result register can take a new item, the dependency logic updates the state
// and loads the result register.
// Throughput is one item per cycle unless the receiver stalls: the whole update
// is one pass of mask logic over the 32 register sets, with no iteration.
// Receiver stall: the result register holds, the input register holds the next
// command, and s_axis_tready drops once both are full.
// Reset (rst_ni low, asynchronous): all slots free, every set and dep mask
// cleared, both registers empty. No clearing pass is needed.
module vector_register_scoreboard
  import vrs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [31:0] read_regs, [63:32] write_regs, [64] masked, [67:65] slot_id, rest 0
  input  logic [InDataW-1:0]  s_axis_tdata,
  // [1:0] kind
  input  logic [KindW-1:0]    s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [0] accepted, [3:1] given_slot, [4] ready_res, [12:5] input_deps,
  // [20:13] output_deps, [21] all_busy, [25:22] pending_count, rest 0
  output logic [OutDataW-1:0] m_axis_tdata
);

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic                in_valid_q, in_valid_d;
  logic [KindW-1:0]    kind_q;
  logic [RegMaskW-1:0] rd_regs_q;
  logic [RegMaskW-1:0] wr_regs_q;
  logic                masked_q;
  logic [SlotIdW-1:0]  sid_q;

  logic out_valid_q, out_valid_d;
  logic advance;   // result register can take a new item
  logic proc;      // command in input register is processed this cycle
  logic in_acc;

  assign advance       = !out_valid_q || m_axis_tready;
  assign proc          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_acc) begin
      in_valid_d = 1'b1;
    end else if (proc) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q    <= s_axis_tuser;
      rd_regs_q <= s_axis_tdata[31:0];
      wr_regs_q <= s_axis_tdata[63:32];
      masked_q  <= s_axis_tdata[64];
      sid_q     <= s_axis_tdata[67:65];
    end
  end

  // ---------------------------------------------------------------------------
  // Scoreboard state
  // ---------------------------------------------------------------------------
  slot_mask_t          reader_sets_q [VregCount];
  slot_mask_t          reader_sets_d [VregCount];
  slot_mask_t          writer_sets_q [VregCount];
  slot_mask_t          writer_sets_d [VregCount];
  slot_mask_t          in_deps_q     [QueueDepth];
  slot_mask_t          in_deps_d     [QueueDepth];
  slot_mask_t          out_deps_q    [QueueDepth];
  slot_mask_t          out_deps_d    [QueueDepth];
  logic [VregCount-1:0] slot_rd_q    [QueueDepth];  // written at issue only
  logic [VregCount-1:0] slot_wr_q    [QueueDepth];
  slot_mask_t          free_q, free_d;
  logic [CntW-1:0]     count_q, count_d;

  // ---------------------------------------------------------------------------
  // Dependency logic
  // ---------------------------------------------------------------------------
  logic [VregCount-1:0] rd_eff;
  logic [VregCount-1:0] wr_eff;
  logic [SlotW-1:0]     alloc_slot;
  logic [SlotW-1:0]     sid_idx;
  logic                 sid_ok;
  slot_mask_t           alloc_bit;
  slot_mask_t           sid_bit;
  slot_mask_t           raw_deps;
  slot_mask_t           wx_deps;
  logic                 do_issue;
  logic                 do_retire;

  logic             res_acc;
  logic [SlotW-1:0] res_slot;
  logic             res_rdy;
  slot_mask_t       res_in;
  slot_mask_t       res_out;

  assign rd_eff    = rd_regs_q[VregCount-1:0] | {{(VregCount-1){1'b0}}, masked_q};
  assign wr_eff    = wr_regs_q[VregCount-1:0];
  assign sid_idx   = sid_q[SlotW-1:0];
  assign sid_ok    = (int'(sid_q) < QueueDepth) && !free_q[sid_idx];
  assign alloc_bit = slot_mask_t'(1) << alloc_slot;
  assign sid_bit   = slot_mask_t'(1) << sid_idx;

  // lowest free slot
  always_comb begin
    alloc_slot = '0;
    for (int i = QueueDepth - 1; i >= 0; i--) begin
      if (free_q[i]) begin
        alloc_slot = SlotW'(i);
      end
    end
  end

  // parallel reduction over the register sets
  always_comb begin
    raw_deps = '0;
    wx_deps  = '0;
    for (int r = 0; r < VregCount; r++) begin
      if (rd_eff[r]) begin
        raw_deps = raw_deps | writer_sets_q[r];
      end
      if (wr_eff[r]) begin
        wx_deps = wx_deps | writer_sets_q[r] | reader_sets_q[r];
      end
    end
    raw_deps = raw_deps & ~alloc_bit;
    wx_deps  = wx_deps & ~alloc_bit;
  end

  always_comb begin
    do_issue  = 1'b0;
    do_retire = 1'b0;
    res_acc   = 1'b0;
    res_slot  = '0;
    res_rdy   = 1'b0;
    res_in    = '0;
    res_out   = '0;
    unique case (kind_q)
      KindIssue: begin
        if (free_q != '0) begin
          do_issue = 1'b1;
          res_acc  = 1'b1;
          res_slot = alloc_slot;
          res_rdy  = (raw_deps == '0) && (wx_deps == '0);
          res_in   = raw_deps;
          res_out  = wx_deps;
        end
      end
      KindRetire: begin
        if (sid_ok) begin
          do_retire = 1'b1;
          res_acc   = 1'b1;
          res_slot  = sid_idx;
          res_rdy   = 1'b1;
        end
      end
      KindQuery: begin
        if (sid_ok) begin
          res_acc  = 1'b1;
          res_slot = sid_idx;
          res_in   = in_deps_q[sid_idx];
          res_out  = out_deps_q[sid_idx];
          res_rdy  = (res_in == '0) && (res_out == '0);
        end
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    reader_sets_d = reader_sets_q;
    writer_sets_d = writer_sets_q;
    in_deps_d     = in_deps_q;
    out_deps_d    = out_deps_q;
    free_d        = free_q;
    count_d       = count_q;
    if (proc && do_issue) begin
      for (int r = 0; r < VregCount; r++) begin
        if (rd_eff[r]) begin
          reader_sets_d[r] = reader_sets_q[r] | alloc_bit;
        end
        if (wr_eff[r]) begin
          writer_sets_d[r] = writer_sets_q[r] | alloc_bit;
        end
      end
      in_deps_d[alloc_slot]  = raw_deps;
      out_deps_d[alloc_slot] = wx_deps;
      free_d  = free_q & ~alloc_bit;
      count_d = count_q + CntW'(1);
    end else if (proc && do_retire) begin
      for (int r = 0; r < VregCount; r++) begin
        if (slot_rd_q[sid_idx][r]) begin
          reader_sets_d[r] = reader_sets_q[r] & ~sid_bit;
        end
        if (slot_wr_q[sid_idx][r]) begin
          writer_sets_d[r] = writer_sets_q[r] & ~sid_bit;
        end
      end
      for (int i = 0; i < QueueDepth; i++) begin
        in_deps_d[i]  = in_deps_q[i] & ~sid_bit;
        out_deps_d[i] = out_deps_q[i] & ~sid_bit;
      end
      in_deps_d[sid_idx]  = '0;
      out_deps_d[sid_idx] = '0;
      free_d = free_q | sid_bit;
      if (count_q != '0) begin
        count_d = count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < VregCount; r++) begin
        reader_sets_q[r] <= '0;
        writer_sets_q[r] <= '0;
      end
      for (int i = 0; i < QueueDepth; i++) begin
        in_deps_q[i]  <= '0;
        out_deps_q[i] <= '0;
      end
      free_q  <= '1;
      count_q <= '0;
    end else begin
      reader_sets_q <= reader_sets_d;
      writer_sets_q <= writer_sets_d;
      in_deps_q     <= in_deps_d;
      out_deps_q    <= out_deps_d;
      free_q        <= free_d;
      count_q       <= count_d;
    end
  end

  // per-slot register masks, read back only when an occupied slot retires
  always_ff @(posedge clk_i) begin
    if (proc && do_issue) begin
      slot_rd_q[alloc_slot] <= rd_eff;
      slot_wr_q[alloc_slot] <= wr_eff;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic [OutDataW-1:0] res_data_q, res_data_d;

  always_comb begin
    res_data_d        = '0;
    res_data_d[0]     = res_acc;
    res_data_d[3:1]   = SlotIdW'(res_slot);
    res_data_d[4]     = res_rdy;
    res_data_d[12:5]  = MaskW'(res_in);
    res_data_d[20:13] = MaskW'(res_out);
    res_data_d[21]    = (int'(count_d) >= QueueDepth);
    res_data_d[25:22] = PendW'(count_d);
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (proc) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      res_data_q <= res_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = res_data_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  logic dep_on_free;

  always_comb begin
    dep_on_free = 1'b0;
    for (int i = 0; i < QueueDepth; i++) begin
      if (((in_deps_q[i] | out_deps_q[i]) & free_q) != '0) begin
        dep_on_free = 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // occupancy counter tracks the free mask
  a_count_matches_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(count_q) == QueueDepth - $countones(free_q))
    else $error("occupancy count disagrees with free slot mask");

  // no slot ever waits on a free slot
  a_no_dep_on_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !dep_on_free)
    else $error("dependency on a free slot");

  // an issued slot is occupied afterwards
  a_issue_takes_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && do_issue |=> !free_q[$past(alloc_slot)])
    else $error("issued slot still marked free");

  // every processed item loads the result register
  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc |=> out_valid_q)
    else $error("processed item produced no result");
`endif

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for vector_register_scoreboard: directed table plus random issue,
// retire and query traffic, each result checked against an in-bench dependency tracker.
// Depends on vrs_pkg and the scoreboard RTL.
`timescale 1ns / 1ps

module tb;
  import vrs_pkg::*;

  // Kind code outside the package enum; the block must ignore it.
  localparam logic [KindW-1:0] KindBogus = 2'd3;

  localparam int ResetCycles  = 5;
  localparam int StallLimit   = 5000;  // cycles with no handshake on either side
  localparam int RandPerPhase = 370;
  localparam int LongHold     = 80;    // receiver hold-off used to fill the block
  localparam int TailCycles   = 10;

  // One command item, fields as they sit in tdata/tuser.
  typedef struct packed {
    logic [KindW-1:0]     kind;
    logic [RegMaskW-1:0]  rd;
    logic [RegMaskW-1:0]  wr;
    logic                 masked;
    logic [SlotIdW-1:0]   sid;
  } cmd_t;

  // One result item, laid out exactly as m_axis_tdata (lowest field last).
  typedef struct packed {
    logic [OutDataW-27:0] pad;
    logic [PendW-1:0]     pending;
    logic                 full;
    logic [MaskW-1:0]     out_deps;
    logic [MaskW-1:0]     in_deps;
    logic                 ready;
    logic [SlotIdW-1:0]   slot;
    logic                 accepted;
  } result_t;

  // Directed table row: the expected result is typed in only when `typed` is set.
  typedef struct {
    cmd_t    c;
    bit      typed;
    result_t want;
  } row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  // [31:0] read_regs, [63:32] write_regs, [64] masked, [67:65] slot_id, rest 0
  logic [InDataW-1:0]  s_axis_tdata;
  // [1:0] kind
  logic [KindW-1:0]    s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  // [0] accepted, [3:1] given_slot, [4] ready_res, [12:5] input_deps,
  // [20:13] output_deps, [21] all_busy, [25:22] pending_count, rest 0
  logic [OutDataW-1:0] m_axis_tdata;

  vector_register_scoreboard u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Dependency tracker: the bench's own copy of the scoreboard state.
  // ---------------------------------------------------------------------------
  slot_mask_t          readers_of [VregCount];   // slots reading each vreg
  slot_mask_t          writers_of [VregCount];   // slots writing each vreg
  slot_mask_t          raw_wait   [QueueDepth];  // producers a slot waits on
  slot_mask_t          hazard_wait[QueueDepth];  // WAR/WAW blockers of a slot
  logic [VregCount-1:0] src_regs_of[QueueDepth];
  logic [VregCount-1:0] dst_regs_of[QueueDepth];
  slot_mask_t          free_slots;
  int                  busy_count;

  result_t results_due[$];  // expected result items, oldest first
  row_t    dir_rows[$];
  int      err_cnt;
  int      src_idle_pct;
  int      sink_idle_pct;
  bit      hold_req;

  // Applies one accepted command to the tracker and returns its result item.
  function automatic result_t resolve_deps(input cmd_t c);
    result_t              res;
    logic [VregCount-1:0] src;
    slot_mask_t           one_hot;
    slot_mask_t           ind;
    slot_mask_t           outd;
    int                   s;
    res = '0;
    src = c.rd;
    ind = '0;
    outd = '0;
    s = 0;
    case (c.kind)
      KindIssue: begin
        if (free_slots != '0) begin
          // lowest free slot wins
          for (int i = QueueDepth - 1; i >= 0; i--) begin
            if (free_slots[i]) s = i;
          end
          one_hot = slot_mask_t'(1) << s;
          if (c.masked) src[0] = 1'b1;  // masked op also reads v0
          for (int r = 0; r < VregCount; r++) begin
            if (src[r]) ind |= writers_of[r];
            if (c.wr[r]) outd |= writers_of[r] | readers_of[r];
          end
          ind &= ~one_hot;
          outd &= ~one_hot;
          for (int r = 0; r < VregCount; r++) begin
            if (src[r]) readers_of[r] |= one_hot;
            if (c.wr[r]) writers_of[r] |= one_hot;
          end
          raw_wait[s]    = ind;
          hazard_wait[s] = outd;
          src_regs_of[s] = src;
          dst_regs_of[s] = c.wr;
          free_slots &= ~one_hot;
          busy_count++;
          res.accepted = 1'b1;
          res.slot     = SlotIdW'(s);
          res.ready    = (ind == '0) && (outd == '0);
          res.in_deps  = ind;
          res.out_deps = outd;
        end
      end
      KindRetire: begin
        if (!free_slots[c.sid]) begin
          one_hot = slot_mask_t'(1) << c.sid;
          for (int r = 0; r < VregCount; r++) begin
            if (src_regs_of[c.sid][r]) readers_of[r] &= ~one_hot;
            if (dst_regs_of[c.sid][r]) writers_of[r] &= ~one_hot;
          end
          for (int i = 0; i < QueueDepth; i++) begin
            raw_wait[i]    &= ~one_hot;
            hazard_wait[i] &= ~one_hot;
          end
          raw_wait[c.sid]    = '0;
          hazard_wait[c.sid] = '0;
          free_slots |= one_hot;
          if (busy_count > 0) busy_count--;
          res.accepted = 1'b1;
          res.slot     = c.sid;
          res.ready    = 1'b1;
        end
      end
      KindQuery: begin
        if (!free_slots[c.sid]) begin
          res.accepted = 1'b1;
          res.slot     = c.sid;
          res.in_deps  = raw_wait[c.sid];
          res.out_deps = hazard_wait[c.sid];
          res.ready    = (raw_wait[c.sid] == '0) && (hazard_wait[c.sid] == '0);
        end
      end
      default: ;  // unknown kind: ignored
    endcase
    res.full    = (busy_count >= QueueDepth);
    res.pending = PendW'(busy_count);
    return res;
  endfunction

  function automatic cmd_t mk_cmd(input logic [KindW-1:0] kind, input logic [31:0] rd,
                                  input logic [31:0] wr, input logic masked,
                                  input logic [SlotIdW-1:0] sid);
    cmd_t c;
    c.kind   = kind;
    c.rd     = rd;
    c.wr     = wr;
    c.masked = masked;
    c.sid    = sid;
    return c;
  endfunction

  // Result with empty dep sets; full follows from the pending count.
  function automatic result_t mk_res(input logic acc, input int slot, input logic rdy,
                                     input int pend);
    result_t r;
    r          = '0;
    r.accepted = acc;
    r.slot     = SlotIdW'(slot);
    r.ready    = rdy;
    r.pending  = PendW'(pend);
    r.full     = (pend >= QueueDepth);
    return r;
  endfunction

  task automatic add_row(input cmd_t c, input bit typed, input result_t want);
    row_t row;
    row.c     = c;
    row.typed = typed;
    row.want  = want;
    dir_rows.push_back(row);
  endtask

  // Mostly sparse masks over v0..v7 so that deps actually collide.
  function automatic logic [RegMaskW-1:0] rand_regs();
    logic [RegMaskW-1:0] m;
    m = '0;
    case ($urandom_range(9))
      0: m = '0;
      1: m = '1;
      2, 3: m = $urandom;
      default: repeat ($urandom_range(1, 3)) m[$urandom_range(7)] = 1'b1;
    endcase
    return m;
  endfunction

  function automatic logic [SlotIdW-1:0] busy_slot();
    logic [SlotIdW-1:0] s;
    s = SlotIdW'($urandom_range(QueueDepth - 1));
    if (busy_count > 0) begin
      while (free_slots[s]) s = SlotIdW'($urandom_range(QueueDepth - 1));
    end
    return s;
  endfunction

  // Well-formed traffic dominates: retire/query mostly name live slots.
  // Noise: bogus kinds, retire/query of free slots, issue while full.
  function automatic cmd_t rand_cmd();
    cmd_t        c;
    int unsigned r;
    r        = $urandom_range(99);
    c.rd     = rand_regs();
    c.wr     = rand_regs();
    c.masked = 1'($urandom_range(1));
    c.sid    = SlotIdW'($urandom_range(QueueDepth - 1));
    if (r < 4) begin
      c.kind = KindBogus;
    end else if (r < 46) begin
      c.kind = KindIssue;
    end else if (r < 74) begin
      c.kind = KindRetire;
      if ($urandom_range(9) != 0) c.sid = busy_slot();
    end else begin
      c.kind = KindQuery;
      if ($urandom_range(9) != 0) c.sid = busy_slot();
    end
    return c;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    err_cnt++;
  endtask

  task automatic check_result(input result_t got, input result_t want);
    if (got.accepted !== want.accepted)
      report_mismatch("accepted", 32'(got.accepted), 32'(want.accepted));
    if (got.slot !== want.slot)
      report_mismatch("given_slot", 32'(got.slot), 32'(want.slot));
    if (got.ready !== want.ready)
      report_mismatch("ready_res", 32'(got.ready), 32'(want.ready));
    if (got.in_deps !== want.in_deps)
      report_mismatch("input_deps", 32'(got.in_deps), 32'(want.in_deps));
    if (got.out_deps !== want.out_deps)
      report_mismatch("output_deps", 32'(got.out_deps), 32'(want.out_deps));
    if (got.full !== want.full)
      report_mismatch("all_busy", 32'(got.full), 32'(want.full));
    if (got.pending !== want.pending)
      report_mismatch("pending_count", 32'(got.pending), 32'(want.pending));
    if (got.pad !== want.pad)
      report_mismatch("tdata padding", 32'(got.pad), 32'(want.pad));
  endtask

  // Offers one item, waits for the handshake, then logs the expectation.
  // The tracker always advances; a typed row overrides only what is expected.
  task automatic drive_cmd(input cmd_t c, input bit typed, input result_t want);
    result_t res;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, c.sid, c.masked, c.wr, c.rd};
    s_axis_tuser  <= c.kind;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    res = resolve_deps(c);
    results_due.push_back(typed ? want : res);
  endtask

  // Sender goes quiet until every outstanding result is back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure, plus a long hold-off on request.
  // ---------------------------------------------------------------------------
  initial begin : sink
    int hold_left;
    hold_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_left = LongHold;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Result checker: values read right after the edge are the ones sampled at it.
  always @(posedge clk_i) begin : monitor
    result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata);
      if (results_due.size() == 0) report_mismatch("unexpected result item", m_axis_tdata, 0);
      else check_result(got, results_due.pop_front());
    end
  end

  // Watchdog: too long without any handshake means the block is hung.
  always @(posedge clk_i) begin : watchdog
    int quiet;
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= StallLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main
    result_t none;
    none = '0;
    err_cnt  = 0;
    hold_req = 1'b0;
    src_idle_pct  = 27;
    sink_idle_pct = 60;
    free_slots = '1;
    busy_count = 0;
    for (int r = 0; r < VregCount; r++) begin
      readers_of[r] = '0;
      writers_of[r] = '0;
    end
    for (int i = 0; i < QueueDepth; i++) begin
      raw_wait[i]    = '0;
      hazard_wait[i] = '0;
      src_regs_of[i] = '0;
      dst_regs_of[i] = '0;
    end
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= KindIssue;

    // Directed table. Slots fill 0..7 in order, then everything retires.
    // After reset: query/retire of a free slot and an unknown kind are ignored.
    add_row(mk_cmd(KindQuery, '0, '0, 1'b0, 0), 1'b1, mk_res(0, 0, 0, 0));
    add_row(mk_cmd(KindRetire, '0, '0, 1'b0, 7), 1'b1, mk_res(0, 0, 0, 0));
    add_row(mk_cmd(KindBogus, '1, '1, 1'b1, 7), 1'b1, mk_res(0, 0, 0, 0));
    // First issue into an empty queue: slot 0, no deps.
    add_row(mk_cmd(KindIssue, '0, '0, 1'b0, 0), 1'b1, mk_res(1, 0, 1, 1));
    add_row(mk_cmd(KindIssue, '0, 32'h1, 1'b0, 0), 1'b0, none);         // writes v0
    add_row(mk_cmd(KindIssue, '0, '0, 1'b1, 0), 1'b0, none);            // masked: RAW on v0
    add_row(mk_cmd(KindIssue, '1, '1, 1'b0, 0), 1'b0, none);            // every register
    add_row(mk_cmd(KindIssue, 32'h8000_0000, 32'h8000_0000, 1'b0, 0), 1'b0, none);
    add_row(mk_cmd(KindQuery, '0, '0, 1'b0, 2), 1'b0, none);
    add_row(mk_cmd(KindQuery, '0, '0, 1'b0, 3), 1'b0, none);
    add_row(mk_cmd(KindIssue, 32'h6, 32'h8, 1'b0, 0), 1'b0, none);
    add_row(mk_cmd(KindIssue, 32'h8, 32'h6, 1'b0, 0), 1'b0, none);
    add_row(mk_cmd(KindIssue, '0, '0, 1'b1, 0), 1'b0, none);            // fills slot 7
    // Issue while full is refused and flagged.
    add_row(mk_cmd(KindIssue, '1, '1, 1'b1, 7), 1'b1, mk_res(0, 0, 0, QueueDepth));
    add_row(mk_cmd(KindQuery, '0, '0, 1'b0, 7), 1'b0, none);
    add_row(mk_cmd(KindRetire, '0, '0, 1'b0, 3), 1'b1, mk_res(1, 3, 1, QueueDepth - 1));
    add_row(mk_cmd(KindQuery, '1, '1, 1'b1, 3), 1'b1, mk_res(0, 0, 0, QueueDepth - 1));
    add_row(mk_cmd(KindIssue, 32'h1, 32'h7FFF_FFFF, 1'b0, 0), 1'b0, none); // reuses slot 3
    for (int s = 0; s < QueueDepth; s++) begin
      add_row(mk_cmd(KindRetire, '0, '0, 1'b0, SlotIdW'(s)), 1'b1,
              mk_res(1, s, 1, QueueDepth - 1 - s));
    end

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) drive_cmd(dir_rows[i].c, dir_rows[i].typed, dir_rows[i].want);
    drain();

    // Phase 0: sender idles 27%, receiver 60%.
    // Phase 1: the other way round. Phase 2: no idling at all.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin src_idle_pct = 27; sink_idle_pct = 60; end
        1: begin src_idle_pct = 60; sink_idle_pct = 27; end
        default: begin src_idle_pct = 0; sink_idle_pct = 0; end
      endcase
      for (int n = 0; n < RandPerPhase; n++) begin
        // long receiver hold-off while items keep coming: input must stall
        if (n == RandPerPhase / 2 && phase != 1) hold_req = 1'b1;
        drive_cmd(rand_cmd(), 1'b0, none);
      end
      drain();
    end

    repeat (TailCycles) @(posedge clk_i);
    if (results_due.size() != 0) report_mismatch("result items never returned", 0,
                                                 results_due.size());
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
